[src/exception_handler_range_lookup_core_defines.svh]
// ----------------------------------------------------------------------------
// Exception range lookup - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef EXCEPTION_HANDLER_RANGE_LOOKUP_CORE_DEFINES_SVH
`define EXCEPTION_HANDLER_RANGE_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication, checked from reset release
`define EHRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EHRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ehrl_pkg.sv]
// ----------------------------------------------------------------------------
// ehrl_pkg
// Constants, codes and the token type passed along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package ehrl_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_BITS   = 32;
  localparam int CLASS_BITS  = 16;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int STAT_W      = 2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNCAUGHT  = 2'd2;
  localparam logic [STAT_W-1:0] ST_WRITTEN   = 2'd3;

  // write: rem = target slot, a..d and h = entry contents
  // lookup: rem = cells still to search, a = address, c = class, h = result
  typedef struct packed {
    logic                  vld;
    logic                  op;
    logic [CNT_W-1:0]      rem;
    logic [ADDR_BITS-1:0]  a;
    logic [ADDR_BITS-1:0]  b;
    logic [CLASS_BITS-1:0] c;
    logic [CLASS_BITS-1:0] d;
    logic [ADDR_BITS-1:0]  h;
    logic                  hit;
  } ehrl_tok_t;

endpackage

`default_nettype wire

[src/ehrl_in_if.sv]
// ----------------------------------------------------------------------------
// ehrl_in_if
// Request channel: valid/ready with write and lookup fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ehrl_in_if import ehrl_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [IDX_W-1:0]      entry_index;
  logic [ADDR_BITS-1:0]  range_start;
  logic [ADDR_BITS-1:0]  range_end;
  logic [CLASS_BITS-1:0] class_low;
  logic [CLASS_BITS-1:0] class_high;
  logic [ADDR_BITS-1:0]  handler_address;
  logic [ADDR_BITS-1:0]  return_address;
  logic [CLASS_BITS-1:0] exception_class;

  modport source (
    output valid, operation, entry_index, range_start, range_end, class_low,
           class_high, handler_address, return_address, exception_class,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, range_start, range_end, class_low,
           class_high, handler_address, return_address, exception_class,
    output ready
  );
endinterface

`default_nettype wire

[src/ehrl_out_if.sv]
// ----------------------------------------------------------------------------
// ehrl_out_if
// Result channel: valid/ready with status and handler.
// ----------------------------------------------------------------------------
`default_nettype none

interface ehrl_out_if import ehrl_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [ADDR_BITS-1:0] found_handler;

  modport source (output valid, status, found_handler, input ready);
  modport sink   (input valid, status, found_handler, output ready);
endinterface

`default_nettype wire

[src/ehrl_cell.sv]
// ----------------------------------------------------------------------------
// ehrl_cell
// One table entry plus one token stage. Writes land when the slot count
// reaches zero; lookups compare while cells remain to be searched.
// ----------------------------------------------------------------------------
`default_nettype none

module ehrl_cell import ehrl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ehrl_tok_t tok_i,
  output ehrl_tok_t      tok_o
);

  logic [ADDR_BITS-1:0]  start_r;
  logic [ADDR_BITS-1:0]  end_r;
  logic [CLASS_BITS-1:0] clo_r;
  logic [CLASS_BITS-1:0] chi_r;
  logic [ADDR_BITS-1:0]  hdl_r;
  ehrl_tok_t             tok_r;
  ehrl_tok_t             tok_nxt;
  logic                  wr_here;
  logic                  active;
  logic                  match;

  assign wr_here = tok_i.vld && (tok_i.op == OP_WRITE) && (tok_i.rem == '0);
  assign active  = (tok_i.rem != '0);
  assign match   = active && (start_r <= tok_i.a) && (tok_i.a < end_r) &&
                   (clo_r <= tok_i.c) && (tok_i.c <= chi_r);

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.op == OP_WRITE) begin
      tok_nxt.rem = tok_i.rem - CNT_W'(1);
      if (wr_here) begin
        tok_nxt.vld = 1'b0;
      end
    end else begin
      tok_nxt.rem = active ? tok_i.rem - CNT_W'(1) : '0;
      if (match && !tok_i.hit) begin
        tok_nxt.hit = 1'b1;
        tok_nxt.h   = hdl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      start_r <= tok_i.a;
      end_r   <= tok_i.b;
      clo_r   <= tok_i.c;
      chi_r   <= tok_i.d;
      hdl_r   <= tok_i.h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

[src/ehrl_chain.sv]
// ----------------------------------------------------------------------------
// ehrl_chain
// Row of TABLE_DEPTH cells; tokens advance one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ehrl_chain import ehrl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ehrl_tok_t tok_i,
  output ehrl_tok_t      tok_o
);

  ehrl_tok_t link [0:TABLE_DEPTH];

  assign link[0] = tok_i;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    ehrl_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (link[k]),
      .tok_o (link[k+1])
    );
  end

  assign tok_o = link[TABLE_DEPTH];

endmodule

`default_nettype wire

[src/exception_handler_range_lookup_core.sv]
// ----------------------------------------------------------------------------
// exception_handler_range_lookup_core
// Exception range table with linear first-match lookup over a cell row.
// ----------------------------------------------------------------------------
// Timing: write and zero-address lookup results are registered from the request;
//   other lookups answer once the token has walked the full cell row.
// Throughput: writes 1 per cycle while the output is not stalled; one lookup
//   in flight, so a non-zero-address lookup blocks new beats until it is done.
// Reset: clears control, entries_in_use and token valids; table contents
//   are left as they are.
`default_nettype none

module exception_handler_range_lookup_core import ehrl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  ehrl_in_if.sink         in_ch,
  ehrl_out_if.source      out_ch
);

  logic [CNT_W-1:0]     entries_in_use_r;
  logic                 busy_r;
  logic                 busy_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [STAT_W-1:0]    status_r;
  logic [STAT_W-1:0]    status_nxt;
  logic [ADDR_BITS-1:0] handler_r;
  logic [ADDR_BITS-1:0] handler_nxt;
  logic                 acc;
  logic                 zero_addr;
  logic                 direct;
  logic                 done;
  ehrl_tok_t            inj;
  ehrl_tok_t            tail;

  assign in_ch.ready = !busy_r && (!out_valid_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;
  assign zero_addr   = (in_ch.return_address == '0);
  assign direct      = acc && ((in_ch.operation == OP_WRITE) || zero_addr);
  assign done        = tail.vld && (tail.op == OP_LOOKUP);

  always_comb begin
    inj     = '0;
    inj.vld = acc && !((in_ch.operation == OP_LOOKUP) && zero_addr);
    inj.op  = in_ch.operation;
    if (in_ch.operation == OP_WRITE) begin
      inj.rem = CNT_W'(in_ch.entry_index);
      inj.a   = in_ch.range_start;
      inj.b   = in_ch.range_end;
      inj.c   = in_ch.class_low;
      inj.d   = in_ch.class_high;
      inj.h   = in_ch.handler_address;
    end else begin
      inj.rem = entries_in_use_r;
      inj.a   = in_ch.return_address;
      inj.c   = in_ch.exception_class;
    end
  end

  ehrl_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .tok_i (inj),
    .tok_o (tail)
  );

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    handler_nxt   = handler_r;
    if (acc && (in_ch.operation == OP_LOOKUP) && !zero_addr) begin
      busy_nxt = 1'b1;
    end
    if (direct) begin
      out_valid_nxt = 1'b1;
      status_nxt    = (in_ch.operation == OP_WRITE) ? ST_WRITTEN : ST_UNCAUGHT;
      handler_nxt   = '0;
    end else if (done) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      status_nxt    = tail.hit ? ST_FOUND : ST_NOT_FOUND;
      handler_nxt   = tail.hit ? tail.h : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= '0;
      busy_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        entries_in_use_r <= cfg_wdata;
      end
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    handler_r <= handler_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.found_handler = handler_r;

endmodule

`default_nettype wire

[src/ehrl_checker.sv]
// ----------------------------------------------------------------------------
// ehrl_checker
// Port-level checks on the lookup core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "exception_handler_range_lookup_core_defines.svh"

module ehrl_checker import ehrl_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 in_operation,
  input wire logic [ADDR_BITS-1:0] in_return_address,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [STAT_W-1:0]    out_status,
  input wire logic [ADDR_BITS-1:0] out_found_handler
);

  `EHRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_found_handler),
    "result beat changed while stalled")

  `EHRL_ASSERT_NEXT(a_write_ack, in_valid && in_ready && (in_operation == OP_WRITE),
    out_valid && (out_status == ST_WRITTEN), "write beat not acknowledged")

  `EHRL_ASSERT_NEXT(a_zero_addr,
    in_valid && in_ready && (in_operation == OP_LOOKUP) && (in_return_address == '0),
    out_valid && (out_status == ST_UNCAUGHT), "zero address not reported uncaught")

  `EHRL_ASSERT_NOW(a_zero_handler,
    out_valid && (out_status == ST_WRITTEN || out_status == ST_UNCAUGHT ||
                  out_status == ST_NOT_FOUND),
    out_found_handler == '0, "handler non-zero without a match")

endmodule

bind exception_handler_range_lookup_core ehrl_checker u_ehrl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_operation      (in_ch.operation),
  .in_return_address (in_ch.return_address),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_found_handler (out_ch.found_handler)
);

`default_nettype wire

[verif/exception_handler_range_lookup_core_test.sv]
// ----------------------------------------------------------------------------
// exception_handler_range_lookup_core_test
// Self-checking bench for the exception range table. Beats are queued with
// their predicted answers, sent in random bursts, and results are compared
// in order while the receiver stalls on its own pattern. The scan length
// is changed between drained phases.
// ----------------------------------------------------------------------------
`default_nettype none

module exception_handler_range_lookup_core_test import ehrl_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT   = 1_000_000;
  localparam int          HOLD_CYCLES = 400;

  typedef struct {
    logic                  op;
    logic [IDX_W-1:0]      slot;
    logic [ADDR_BITS-1:0]  lo_addr;
    logic [ADDR_BITS-1:0]  hi_addr;
    logic [CLASS_BITS-1:0] cls_lo;
    logic [CLASS_BITS-1:0] cls_hi;
    logic [ADDR_BITS-1:0]  handler;
    logic [ADDR_BITS-1:0]  ret_addr;
    logic [CLASS_BITS-1:0] cls;
  } request_t;

  typedef struct {
    logic [STAT_W-1:0]    status;
    logic [ADDR_BITS-1:0] handler;
  } answer_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CNT_W-1:0]     cfg_wdata;

  ehrl_in_if  req_ch ();
  ehrl_out_if rsp_ch ();

  exception_handler_range_lookup_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch)
  );

  request_t pending_reqs[$];
  answer_t  awaited_answers[$];

  // bench copy of the range table and the scan length
  logic [ADDR_BITS-1:0]  range_lo_tbl [TABLE_DEPTH];
  logic [ADDR_BITS-1:0]  range_hi_tbl [TABLE_DEPTH];
  logic [CLASS_BITS-1:0] cls_lo_tbl   [TABLE_DEPTH];
  logic [CLASS_BITS-1:0] cls_hi_tbl   [TABLE_DEPTH];
  logic [ADDR_BITS-1:0]  handler_tbl  [TABLE_DEPTH];
  logic [CNT_W-1:0]      scan_len;

  int          fault_count = 0;
  int          result_beats = 0;
  int          seen_status [4] = '{0, 0, 0, 0};
  int          setting_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          ready_pct = 100;
  int          pattern_left = 0;
  int          hold_left = 0;
  int          hold_beats = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  always #4 clk = ~clk;

  function automatic answer_t handler_answer(request_t r);
    answer_t a;
    int      n;
    a.handler = '0;
    if (r.op == OP_WRITE) begin
      range_lo_tbl[r.slot] = r.lo_addr;
      range_hi_tbl[r.slot] = r.hi_addr;
      cls_lo_tbl[r.slot]   = r.cls_lo;
      cls_hi_tbl[r.slot]   = r.cls_hi;
      handler_tbl[r.slot]  = r.handler;
      a.status = ST_WRITTEN;
    end else if (r.ret_addr == '0) begin
      a.status = ST_UNCAUGHT;
    end else begin
      n = (scan_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_len);
      a.status = ST_NOT_FOUND;
      for (int k = 0; k < n; k++) begin
        if (range_lo_tbl[k] <= r.ret_addr && r.ret_addr < range_hi_tbl[k] &&
            cls_lo_tbl[k] <= r.cls && r.cls <= cls_hi_tbl[k]) begin
          a.status  = ST_FOUND;
          a.handler = handler_tbl[k];
          break;
        end
      end
    end
    return a;
  endfunction

  function automatic request_t noise_request();
    request_t r;
    r.op       = 1'($urandom_range(0, 1));
    r.slot     = IDX_W'($urandom);
    r.lo_addr  = $urandom;
    r.hi_addr  = $urandom;
    r.cls_lo   = CLASS_BITS'($urandom);
    r.cls_hi   = CLASS_BITS'($urandom);
    r.handler  = $urandom;
    r.ret_addr = $urandom;
    r.cls      = CLASS_BITS'($urandom);
    return r;
  endfunction

  task automatic post(request_t r);
    awaited_answers.push_back(handler_answer(r));
    pending_reqs.push_back(r);
  endtask

  task automatic post_write(int unsigned slot, logic [ADDR_BITS-1:0] lo, logic [ADDR_BITS-1:0] hi,
                            logic [CLASS_BITS-1:0] cl, logic [CLASS_BITS-1:0] ch,
                            logic [ADDR_BITS-1:0] h);
    request_t r;
    r = noise_request();
    r.op      = OP_WRITE;
    r.slot    = IDX_W'(slot);
    r.lo_addr = lo;
    r.hi_addr = hi;
    r.cls_lo  = cl;
    r.cls_hi  = ch;
    r.handler = h;
    post(r);
  endtask

  task automatic post_lookup(logic [ADDR_BITS-1:0] addr, logic [CLASS_BITS-1:0] cls);
    request_t r;
    r = noise_request();
    r.op       = OP_LOOKUP;
    r.ret_addr = addr;
    r.cls      = cls;
    post(r);
  endtask

  task automatic post_random_write(int unsigned slot);
    logic [ADDR_BITS-1:0]  lo;
    logic [ADDR_BITS-1:0]  hi;
    logic [CLASS_BITS-1:0] cl;
    logic [CLASS_BITS-1:0] ch;
    logic [ADDR_BITS-1:0]  h;
    lo = $urandom_range(1, 2000);
    hi = lo + $urandom_range(1, 300);
    cl = CLASS_BITS'($urandom_range(0, 30));
    ch = cl + CLASS_BITS'($urandom_range(0, 12));
    h  = ($urandom_range(0, 15) == 0) ? '0 : $urandom;
    case ($urandom_range(0, 9))
      0: begin
        lo = $urandom;
        hi = $urandom;
        cl = CLASS_BITS'($urandom);
        ch = CLASS_BITS'($urandom);
      end
      1: hi = lo - $urandom_range(0, 3);
      2: begin
        cl = CLASS_BITS'($urandom_range(1, 40));
        ch = CLASS_BITS'($urandom_range(0, cl - 1));
      end
      default: ;
    endcase
    post_write(slot, lo, hi, cl, ch, h);
  endtask

  task automatic post_random_lookup();
    case ($urandom_range(0, 19))
      0: post_lookup('0, CLASS_BITS'($urandom));
      1: post_lookup($urandom, CLASS_BITS'($urandom));
      2: post_lookup('1, CLASS_BITS'($urandom));
      default: post_lookup($urandom_range(1, 2300), CLASS_BITS'($urandom_range(0, 45)));
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || awaited_answers.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic set_scan_len(logic [CNT_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    scan_len = v;
    setting_count++;
  endtask

  // request driver: bursts with random gaps
  always @(posedge clk) begin
    request_t r;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!(req_ch.valid && !req_ch.ready)) begin
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        req_ch.valid <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        req_ch.operation       <= r.op;
        req_ch.entry_index     <= r.slot;
        req_ch.range_start     <= r.lo_addr;
        req_ch.range_end       <= r.hi_addr;
        req_ch.class_low       <= r.cls_lo;
        req_ch.class_high      <= r.cls_hi;
        req_ch.handler_address <= r.handler;
        req_ch.return_address  <= r.ret_addr;
        req_ch.exception_class <= r.cls;
        req_ch.valid           <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          if ($urandom_range(0, 3) == 0) gap_left = 0;
          else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(20, 90);
          else gap_left = $urandom_range(1, 6);
        end
      end
    end
  end

  // result receiver: stall density changes in stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end else begin
        pattern_left--;
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // one long hold-off so the block backs up into the request side
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) hold_beats++;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && hold_beats >= 150) begin
      hold_left <= HOLD_CYCLES;
      hold_done = 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      result_beats++;
      seen_status[rsp_ch.status]++;
      if (awaited_answers.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("result beat %0d unexpected: status %0d handler %h",
                   result_beats, rsp_ch.status, rsp_ch.found_handler);
      end else begin
        want = awaited_answers.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.found_handler !== want.handler) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result beat %0d: expected status %0d handler %h, got status %0d handler %h",
                     result_beats, want.status, want.handler, rsp_ch.status,
                     rsp_ch.found_handler);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("run limit of %0d cycles reached, %0d results outstanding",
               RUN_LIMIT, awaited_answers.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0] v;
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    scan_len               = '0;
    req_ch.valid           = 1'b0;
    req_ch.operation       = OP_WRITE;
    req_ch.entry_index     = '0;
    req_ch.range_start     = '0;
    req_ch.range_end       = '0;
    req_ch.class_low       = '0;
    req_ch.class_high      = '0;
    req_ch.handler_address = '0;
    req_ch.return_address  = '0;
    req_ch.exception_class = '0;
    rsp_ch.ready           = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty scan, then top of stack
    post_lookup(32'h1, '0);
    post_lookup('0, '1);
    post_write(0, 32'h100, 32'h200, 16'd10, 16'd20, 32'hAAAA_0000);
    post_write(1, 32'h100, 32'h100, '0, '1, 32'h1);
    post_write(2, '0, '1, 16'd50, 16'd40, 32'h2);
    post_write(3, '0, 32'hFFFF_FFF0, '0, '1, '0);
    post_write(4, 32'hFFFF_FFFE, '1, '0, '1, '1);
    post_write(5, 32'h100, 32'h200, 16'd10, 16'd20, 32'h5555_5555);
    set_scan_len(7'd6);
    post_lookup(32'h100, 16'd10);
    post_lookup(32'h1FF, 16'd20);
    post_lookup(32'h1FF, 16'd21);
    post_lookup(32'h200, 16'd15);
    post_lookup(32'h100, 16'd9);
    post_lookup(32'h150, 16'd45);
    post_lookup(32'hFFFF_FFFE, '1);
    post_lookup('1, '1);
    post_lookup('0, 16'd15);
    set_scan_len(7'd1);
    post_lookup(32'h200, 16'd15);
    post_lookup(32'h150, 16'd15);

    // fill the whole table before wider scans
    for (int s = 0; s < TABLE_DEPTH; s++) post_random_write(s);

    for (int p = 0; p < 13; p++) begin
      case (p)
        0: v = 7'd64;
        1: v = 7'd127;
        2: v = 7'd0;
        3: v = 7'd1;
        4: v = 7'd65;
        default: v = ($urandom_range(0, 3) == 0) ? 7'd64 : 7'($urandom_range(0, 127));
      endcase
      set_scan_len(v);
      repeat (128) begin
        if ($urandom_range(0, 9) < 4) post_random_write($urandom_range(0, TABLE_DEPTH - 1));
        else post_random_lookup();
      end
    end

    drain();
    $display("covered %0d writes and %0d lookups over %0d scan lengths",
             seen_status[ST_WRITTEN],
             result_beats - seen_status[ST_WRITTEN], setting_count);
    $display("lookups: %0d found, %0d not found, %0d uncaught; %0d mismatches",
             seen_status[ST_FOUND], seen_status[ST_NOT_FOUND], seen_status[ST_UNCAUGHT],
             fault_count);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+src
src/ehrl_pkg.sv
src/ehrl_in_if.sv
src/ehrl_out_if.sv
src/ehrl_cell.sv
src/ehrl_chain.sv
src/exception_handler_range_lookup_core.sv
src/ehrl_checker.sv
verif/exception_handler_range_lookup_core_test.sv
